[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ccp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_pkg
// Types and constants shared by the circle canvas painter.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int CCP_MAX_SIDE = 256;

  localparam logic [7:0] KIND_OUTLINE = 8'h63;
  localparam logic [7:0] KIND_FILLED  = 8'h43;

  localparam logic [8:0] WIDTH_RESET  = 9'd1;
  localparam logic [8:0] HEIGHT_RESET = 9'd1;
  localparam logic [7:0] BG_RESET     = 8'd32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BG     = 2'd2;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_DRAW  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } ccp_mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_KIND   = 2'd1,
    ST_BAD_RADIUS = 2'd2
  } ccp_status_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         shape_kind;
    logic signed [19:0] center_x;
    logic signed [19:0] center_y;
    logic signed [19:0] radius;
    logic [7:0]         fill_char;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
  } ccp_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] pixel_value;
  } ccp_out_t;

  // Command from the controller to the scan engine.
  typedef struct packed {
    logic               go;
    logic               clear;
    logic               outline;
    logic [7:0]         data;
    logic signed [19:0] cx;
    logic signed [19:0] cy;
    logic signed [19:0] rad;
  } ccp_cmd_t;

endpackage

[hdl/ccp_canvas_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_canvas_mem
// Single-port-write, single-port-read canvas memory with registered read data.
// ----------------------------------------------------------------------------
module ccp_canvas_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

[hdl/ccp_scan_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_scan_engine
// Walks every pixel in use and writes the covered ones through a
// two-stage distance pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ccp_scan_engine #(
  parameter int  MAX_SIDE = ccp_pkg::CCP_MAX_SIDE,
  localparam int CW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
  localparam int SW  = $clog2(MAX_SIDE + 1),
  localparam int AW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ccp_pkg::ccp_cmd_t cmd,
  input  logic [SW-1:0]    width_use,
  input  logic [SW-1:0]    height_use,
  output logic             done_r,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [7:0]       wr_data
);
  import ccp_pkg::*;

  // Signed offset of a pixel from the center, and its square.
  localparam int DW  = $clog2((MAX_SIDE - 1) * 256 + 524289) + 1;
  localparam int SQW = 2 * DW;

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_SCAN, S_DRAIN} state_t;

  state_t                state_r;
  logic [CW-1:0]         x_r, y_r;
  logic [AW-1:0]         row_base_r;
  logic [SW-1:0]         w_r, h_r;
  logic                  clear_r, outline_r, inner_ok_r;
  logic [7:0]            data_r;
  logic signed [19:0]    cx_r, cy_r, rad_r;
  logic [SQW-1:0]        outer_r, inner_r;
  logic signed [20:0]    inner_rad;

  logic                  a_valid_r, b_valid_r;
  logic signed [DW-1:0]  a_dx_r, a_dy_r;
  logic [AW-1:0]         a_addr_r, b_addr_r;
  logic [SQW-1:0]        b_dx2_r, b_dy2_r;
  logic [SQW:0]          d2;
  logic                  hit;

  assign inner_rad = {rad_r[19], rad_r} - 21'sd256;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd.go) begin
            clear_r    <= cmd.clear;
            outline_r  <= cmd.outline;
            data_r     <= cmd.data;
            cx_r       <= cmd.cx;
            cy_r       <= cmd.cy;
            rad_r      <= cmd.rad;
            w_r        <= width_use;
            h_r        <= height_use;
            x_r        <= '0;
            y_r        <= '0;
            row_base_r <= '0;
            state_r    <= S_SETUP;
          end
        end
        S_SETUP: begin
          outer_r    <= rad_r * rad_r;
          inner_r    <= inner_rad * inner_rad;
          inner_ok_r <= !inner_rad[20];
          // An empty canvas has nothing to visit.
          if (w_r == '0 || h_r == '0) begin
            state_r <= S_DRAIN;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (SW'(x_r) + SW'(1) == w_r) begin
            x_r <= '0;
            if (SW'(y_r) + SW'(1) == h_r) begin
              state_r <= S_DRAIN;
            end else begin
              y_r        <= y_r + CW'(1);
              row_base_r <= row_base_r + AW'(MAX_SIDE);
            end
          end else begin
            x_r <= x_r + CW'(1);
          end
        end
        S_DRAIN: begin
          if (!a_valid_r && !b_valid_r) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Distance pipeline: offsets, then squares, then compare at the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= (state_r == S_SCAN);
      b_valid_r <= a_valid_r;
    end
    a_dx_r   <= $signed({1'b0, x_r, 8'h00}) - cx_r;
    a_dy_r   <= $signed({1'b0, y_r, 8'h00}) - cy_r;
    a_addr_r <= row_base_r + AW'(x_r);
    b_dx2_r  <= a_dx_r * a_dx_r;
    b_dy2_r  <= a_dy_r * a_dy_r;
    b_addr_r <= a_addr_r;
  end

  assign d2  = {1'b0, b_dx2_r} + {1'b0, b_dy2_r};
  assign hit = clear_r ||
               (d2 <= {1'b0, outer_r} &&
                !(outline_r && inner_ok_r && d2 <= {1'b0, inner_r}));

  assign wr_en   = b_valid_r && hit;
  assign wr_addr = b_addr_r;
  assign wr_data = data_r;

  `CCP_ASSERT_IMP(a_wr_during_scan, clk, rst_n, wr_en, (state_r == S_SCAN || state_r == S_DRAIN), "canvas write outside a scan")
  `CCP_ASSERT_IMP(a_done_drained, clk, rst_n, done_r, (!a_valid_r && !b_valid_r && state_r == S_IDLE), "done raised with pixels in flight")

endmodule

[hdl/circle_canvas_painter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_canvas_painter
// Byte canvas with clear, circle draw and pixel read, held in one memory.
// ----------------------------------------------------------------------------
// Clear and good draws visit the canvas in use one pixel per cycle in the scan
// engine. A read inside the canvas waits for the registered memory read; errors,
// reads outside the canvas and mode three are answered straight from idle. busy
// is low whenever out_valid is high, so a new word can be taken at the edge that
// takes the result. Results cannot be stalled.
// Reset sets width 1, height 1, background 32; the canvas is undefined until written.
`include "assert_macros.svh"
module circle_canvas_painter #(
  parameter int MAX_SIDE = ccp_pkg::CCP_MAX_SIDE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ccp_pkg::ccp_in_t in_word,
  output logic             out_valid,
  output ccp_pkg::ccp_out_t out_word,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ccp_pkg::*;

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;

  typedef enum logic [1:0] {S_IDLE, S_PAINT, S_READ} state_t;

  state_t        state_r;
  logic [8:0]    width_r, height_r;
  logic [7:0]    bg_r;
  logic          out_valid_r;
  ccp_out_t      out_word_r;
  logic [SW-1:0] w_use, h_use;
  logic          accept, kind_ok, rad_bad, pix_inside;
  ccp_cmd_t      cmd;
  logic          eng_done;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  // Register file.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      bg_r     <= BG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_r  <= pwdata[8:0];
        REG_HEIGHT: height_r <= pwdata[8:0];
        REG_BG:     bg_r     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {23'd0, width_r};
      REG_HEIGHT: prdata = {23'd0, height_r};
      REG_BG:     prdata = {24'd0, bg_r};
      default:    prdata = '0;
    endcase
  end

  assign w_use = (32'(width_r) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(width_r);
  assign h_use = (32'(height_r) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(height_r);

  // Command decode.
  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign kind_ok    = (in_word.shape_kind == KIND_OUTLINE) ||
                      (in_word.shape_kind == KIND_FILLED);
  assign rad_bad    = in_word.radius[19] || (in_word.radius == '0);
  assign pix_inside = (32'(in_word.pixel_x) < 32'(w_use)) &&
                      (32'(in_word.pixel_y) < 32'(h_use));
  assign rd_addr    = AW'(32'(in_word.pixel_y) * MAX_SIDE + 32'(in_word.pixel_x));

  always_comb begin
    cmd.go      = 1'b0;
    cmd.clear   = (ccp_mode_t'(in_word.mode) == MODE_CLEAR);
    cmd.outline = (in_word.shape_kind == KIND_OUTLINE);
    cmd.data    = cmd.clear ? bg_r : in_word.fill_char;
    cmd.cx      = in_word.center_x;
    cmd.cy      = in_word.center_y;
    cmd.rad     = in_word.radius;
    if (accept) begin
      unique case (ccp_mode_t'(in_word.mode))
        MODE_CLEAR: cmd.go = 1'b1;
        MODE_DRAW:  cmd.go = !rad_bad && kind_ok;
        MODE_READ:  cmd.go = 1'b0;
        MODE_NONE:  cmd.go = 1'b0;
        default:    cmd.go = 1'b0;
      endcase
    end
  end

  // Controller: immediate answers, or wait for the engine or the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_word_r.status      <= ST_OK;
            out_word_r.pixel_value <= '0;
            unique case (ccp_mode_t'(in_word.mode))
              MODE_CLEAR: state_r <= S_PAINT;
              MODE_DRAW: begin
                if (rad_bad) begin
                  out_word_r.status <= ST_BAD_RADIUS;
                  out_valid_r       <= 1'b1;
                end else if (!kind_ok) begin
                  out_word_r.status <= ST_BAD_KIND;
                  out_valid_r       <= 1'b1;
                end else begin
                  state_r <= S_PAINT;
                end
              end
              MODE_READ: begin
                if (pix_inside) begin
                  state_r <= S_READ;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_PAINT: begin
          if (eng_done) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_READ: begin
          out_word_r.pixel_value <= rd_data;
          out_valid_r            <= 1'b1;
          state_r                <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  ccp_scan_engine #(
    .MAX_SIDE(MAX_SIDE)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .width_use (w_use),
    .height_use(h_use),
    .done_r    (eng_done),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  ccp_canvas_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data_r(rd_data)
  );

  `CCP_ASSERT_IMP(a_done_in_paint, clk, rst_n, eng_done, state_r == S_PAINT, "engine done while not painting")
  `CCP_ASSERT_NXT(a_read_answers, clk, rst_n, state_r == S_READ, (out_valid_r && state_r == S_IDLE), "read did not answer")

endmodule

[dv/circle_canvas_painter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_canvas_painter_tb
// Self-checking bench for the circle canvas painter. A scoreboard keeps its
// own copy of the canvas and the size registers and computes the answer to
// every accepted command. Directed commands cover the named corner cases, and
// random phases on small canvases follow them.
// ----------------------------------------------------------------------------
module circle_canvas_painter_tb;
  import ccp_pkg::*;

  localparam int SIDE       = CCP_MAX_SIDE;
  localparam int ONE_PIXEL  = 256;
  localparam int TIMEOUT_NS = 5_000_000;

  class paint_checker;
    logic [7:0] canvas [SIDE*SIDE];
    logic [8:0] cols_reg;
    logic [8:0] rows_reg;
    logic [7:0] bg_reg;
    ccp_out_t   expected_q[$];
    int mismatches;
    int n_clear;
    int n_draw;
    int n_reject;
    int n_read;
    int n_none;

    function new();
      cols_reg   = WIDTH_RESET;
      rows_reg   = HEIGHT_RESET;
      bg_reg     = BG_RESET;
      mismatches = 0;
      n_clear    = 0;
      n_draw     = 0;
      n_reject   = 0;
      n_read     = 0;
      n_none     = 0;
      foreach (canvas[i]) canvas[i] = 8'h00;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_WIDTH:  cols_reg = value[8:0];
        REG_HEIGHT: rows_reg = value[8:0];
        REG_BG:     bg_reg   = value[7:0];
        default: ;
      endcase
    endfunction

    function ccp_out_t paint_and_answer(ccp_in_t cmd);
      ccp_out_t ans;
      int       cols;
      int       rows;
      longint   cx;
      longint   cy;
      longint   rad;
      longint   inner_r;
      longint   outer_sq;
      longint   inner_sq;
      longint   dx;
      longint   dy;
      longint   d2;
      bit       hit;
      ans  = '0;
      cols = (cols_reg > SIDE) ? SIDE : int'(cols_reg);
      rows = (rows_reg > SIDE) ? SIDE : int'(rows_reg);
      cx   = cmd.center_x;
      cy   = cmd.center_y;
      rad  = cmd.radius;
      case (ccp_mode_t'(cmd.mode))
        MODE_CLEAR: begin
          n_clear++;
          for (int y = 0; y < rows; y++)
            for (int x = 0; x < cols; x++)
              canvas[y*SIDE + x] = bg_reg;
        end
        MODE_DRAW: begin
          n_draw++;
          if (rad <= 0) begin
            ans.status = ST_BAD_RADIUS;
          end else if (cmd.shape_kind != KIND_OUTLINE && cmd.shape_kind != KIND_FILLED) begin
            ans.status = ST_BAD_KIND;
          end else begin
            outer_sq = rad * rad;
            inner_r  = rad - ONE_PIXEL;
            inner_sq = inner_r * inner_r;
            for (int y = 0; y < rows; y++) begin
              dy = longint'(y) * ONE_PIXEL - cy;
              for (int x = 0; x < cols; x++) begin
                dx  = longint'(x) * ONE_PIXEL - cx;
                d2  = dx * dx + dy * dy;
                hit = (d2 <= outer_sq);
                // An outline with a negative inner radius keeps every covered pixel.
                if (hit && cmd.shape_kind == KIND_OUTLINE && inner_r >= 0 && d2 <= inner_sq)
                  hit = 1'b0;
                if (hit) canvas[y*SIDE + x] = cmd.fill_char;
              end
            end
          end
          if (ans.status != ST_OK) n_reject++;
        end
        MODE_READ: begin
          n_read++;
          if (cmd.pixel_x < cols && cmd.pixel_y < rows)
            ans.pixel_value = canvas[{cmd.pixel_y, cmd.pixel_x}];
        end
        default: n_none++;
      endcase
      return ans;
    endfunction

    function void note_command(ccp_in_t cmd);
      expected_q.push_back(paint_and_answer(cmd));
    endfunction

    function void check_answer(ccp_out_t got);
      ccp_out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: status %0d pixel %02h",
                 $time, got.status, got.pixel_value);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
      if (got.pixel_value !== want.pixel_value) begin
        mismatches++;
        $display("%0t: pixel mismatch: expected %02h, actual %02h",
                 $time, want.pixel_value, got.pixel_value);
      end
    endfunction
  endclass

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  ccp_in_t     in_word = '0;
  logic        out_valid;
  ccp_out_t    out_word;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  paint_checker sb;
  bit           idle_on;
  int           cur_cols;
  int           cur_rows;
  int           settings_used;

  circle_canvas_painter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_answer(out_word);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timed out", $time);
    $display("FAILURE");
    $finish;
  end

  // The start line stays high across back-to-back words; it only drops for
  // an idle burst or when the sender waits for the block to drain.
  task automatic send_cmd(input ccp_in_t cmd);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(cmd);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_canvas(input int cols, input int rows, input logic [7:0] bg);
    drain();
    cfg_write(REG_WIDTH, 32'(cols));
    cfg_write(REG_HEIGHT, 32'(rows));
    cfg_write(REG_BG, {24'h0, bg});
    cur_cols = (cols > SIDE) ? SIDE : cols;
    cur_rows = (rows > SIDE) ? SIDE : rows;
    settings_used++;
  endtask

  function automatic ccp_in_t make_cmd(ccp_mode_t mode, logic [7:0] kind, int cx, int cy,
                                       int rad, logic [7:0] fill, logic [7:0] px,
                                       logic [7:0] py);
    ccp_in_t c;
    c.mode       = mode;
    c.shape_kind = kind;
    c.center_x   = 20'(cx);
    c.center_y   = 20'(cy);
    c.radius     = 20'(rad);
    c.fill_char  = fill;
    c.pixel_x    = px;
    c.pixel_y    = py;
    return c;
  endfunction

  // Centers fall a few pixels around the canvas so circles also clip.
  function automatic logic signed [19:0] random_coord(int n);
    if ($urandom_range(0, 2) == 0)
      return 20'(int'($urandom_range(0, n + 2)) * ONE_PIXEL);
    return 20'(int'($urandom_range(0, (n + 6) * ONE_PIXEL)) - 3 * ONE_PIXEL);
  endfunction

  function automatic ccp_in_t random_cmd(int cols, int rows);
    ccp_in_t     c;
    logic [95:0] noise;
    int          pick;
    noise = {$urandom, $urandom, $urandom};
    c     = noise[$bits(ccp_in_t)-1:0];
    pick  = $urandom_range(0, 99);
    if (pick < 10) begin
      c.mode = MODE_CLEAR;
    end else if (pick < 55) begin
      c.mode       = MODE_DRAW;
      c.shape_kind = $urandom_range(0, 1) ? KIND_FILLED : KIND_OUTLINE;
      c.center_x   = random_coord(cols);
      c.center_y   = random_coord(rows);
      c.radius     = $urandom_range(0, 1) ? 20'($urandom_range(1, 8) * ONE_PIXEL)
                                          : 20'($urandom_range(1, 8 * ONE_PIXEL));
    end else if (pick < 85) begin
      c.mode    = MODE_READ;
      c.pixel_x = 8'($urandom_range(0, cols - 1));
      c.pixel_y = 8'($urandom_range(0, rows - 1));
    end else if (pick < 92) begin
      c.mode = MODE_DRAW;
      if ($urandom_range(0, 1))
        c.radius = 20'(-int'($urandom_range(0, 524288)));
      else
        c.radius = 20'($urandom_range(1, 524287));
    end
    return c;
  endfunction

  initial begin
    sb            = new();
    idle_on       = 1'b1;
    settings_used = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The whole store is cleared first, so no later read can hit a pixel
    // that was never written.
    set_canvas(256, 256, 8'h2E);
    send_cmd(make_cmd(MODE_CLEAR, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_DRAW, KIND_FILLED, 128*256 + 128, 100*256 + 64, 60*256 + 192,
                      8'h23, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd128, 8'd100));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd189, 8'd100));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd255, 8'd255));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd0, 8'd0));

    // Zero columns and rows: clear and draw leave everything alone.
    set_canvas(0, 0, 8'h55);
    send_cmd(make_cmd(MODE_CLEAR, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_DRAW, KIND_FILLED, 0, 0, 4*256, 8'h77, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd0, 8'd0));

    // A width above the maximum acts as the maximum. Outlines of radius one
    // pixel skip the exact center; smaller ones keep every covered pixel.
    set_canvas(300, 2, 8'hFF);
    send_cmd(make_cmd(MODE_CLEAR, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_DRAW, KIND_OUTLINE, 3*256, 256, 256, 8'h6F, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_DRAW, KIND_OUTLINE, 250*256, 0, 200, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd3, 8'd1));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd2, 8'd1));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd250, 8'd0));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd255, 8'd1));

    // One pixel canvas with the rejected draws and the field extremes.
    set_canvas(1, 1, 8'h00);
    send_cmd(make_cmd(MODE_CLEAR, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_DRAW, 8'h00, 0, 0, 0, 8'hFF, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_DRAW, 8'hFF, 0, 0, 300, 8'hFF, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_DRAW, KIND_FILLED, 0, 0, -524288, 8'hFF, 8'h00, 8'h00));
    send_cmd(make_cmd(MODE_DRAW, KIND_OUTLINE, 524287, 524287, 524287, 8'hFF,
                      8'h00, 8'h00));
    send_cmd(make_cmd(MODE_DRAW, KIND_FILLED, -524288, -524288, 524287, 8'hAB,
                      8'h00, 8'h00));
    send_cmd(make_cmd(MODE_NONE, 8'hFF, -1, -1, -1, 8'hFF, 8'hFF, 8'hFF));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd255, 8'd255));
    send_cmd(make_cmd(MODE_READ, 8'h00, 0, 0, 0, 8'h00, 8'd0, 8'd0));

    // Random phases on small canvases; the last one runs without idling.
    for (int p = 0; p < 5; p++) begin
      if (p == 4) idle_on = 1'b0;
      if (p == 1)
        set_canvas(256, $urandom_range(1, 2), 8'($urandom_range(0, 255)));
      else
        set_canvas($urandom_range(1, 16), $urandom_range(1, 16),
                   8'($urandom_range(0, 255)));
      repeat (15) send_cmd(random_cmd(cur_cols, cur_rows));
    end

    drain();
    repeat (20) @(posedge clk);

    $display("Run covered %0d clears, %0d draws (%0d rejected), %0d reads, %0d no-ops",
             sb.n_clear, sb.n_draw, sb.n_reject, sb.n_read, sb.n_none);
    $display("over %0d canvas settings from empty to full size.", settings_used);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/ccp_pkg.sv
hdl/ccp_canvas_mem.sv
hdl/ccp_scan_engine.sv
hdl/circle_canvas_painter.sv
dv/circle_canvas_painter_tb.sv
